// ===== sv/fpr_pkg.sv =====
// Shared types and constants for the framed packet receiver.
// Used by fpr_step, framed_packet_receiver and its checker; no dependencies.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int unsigned HDR_LEN      = 5;  // start, module, command, length hi/lo
  localparam int unsigned FLAGS_BYTES  = 4;
  localparam int unsigned SUM_END      = 6;  // flags plus two checksum bytes
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_SYMBOL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_SYMBOL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODULE_ID   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_BYTES  = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_PAY  = 2'd2,
    PH_FOOT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  start_symbol;
    logic [7:0]  end_symbol;
    logic [7:0]  max_module_id;
    logic [15:0] max_payload_len;
    logic [15:0] capacity_bytes;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] byte_index;
    logic [7:0]  held_module;
    logic [7:0]  held_command;
    logic [15:0] held_length;
    logic [31:0] flags_shift;
    logic [15:0] running_sum;
    logic [15:0] received_sum;
    logic [1:0]  header_faults;  // bit 0 module, bit 1 length
  } rx_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  module_id;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic [31:0] frame_flags;
    logic        start_error;
    logic        overflow_error;
    logic        module_error;
    logic        length_error;
    logic        checksum_error;
    logic        end_error;
  } result_t;

  localparam rx_state_t STATE_RESET = '{
    phase: PH_HUNT, byte_index: 16'd0, held_module: 8'd0, held_command: 8'd0,
    held_length: 16'd0, flags_shift: 32'd0, running_sum: 16'd0,
    received_sum: 16'd0, header_faults: 2'd0
  };

endpackage

// ===== sv/fpr_step.sv =====
// Per-byte receive logic: next receiver state and the result for one transaction.
// Purely combinational; depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_step import fpr_pkg::*; (
  input  rx_state_t st,
  input  cfg_t      cfg,
  input  logic      func,
  input  logic [7:0] rx_byte,
  output rx_state_t st_next,
  output result_t   res
);

  logic        overflow;
  logic [15:0] idx_inc;
  logic [15:0] sum_add;
  logic [16:0] frame_end;
  logic [16:0] pos_diff;
  logic        past_payload;
  logic        in_flags;
  logic        in_sum;
  logic [15:0] expect_sum;

  assign overflow     = st.byte_index >= cfg.capacity_bytes;
  assign idx_inc      = st.byte_index + 16'd1;
  assign sum_add      = st.running_sum + {8'd0, rx_byte};
  assign frame_end    = 17'(HDR_LEN) + {1'b0, st.held_length};
  // footer position; below the payload end it counts as far beyond the footer
  assign pos_diff     = {1'b0, st.byte_index} - frame_end;
  assign past_payload = {1'b0, st.byte_index} >= frame_end;
  assign in_flags     = past_payload && (pos_diff < 17'(FLAGS_BYTES));
  assign in_sum       = past_payload && (pos_diff < 17'(SUM_END));
  assign expect_sum   = ~st.running_sum + 16'd1;

  // next state
  always_comb begin
    st_next = st;
    if (func) begin
      st_next.phase      = PH_HUNT;
      st_next.byte_index = 16'd0;
    end else if (!overflow) begin
      case (st.phase)
        PH_HUNT: begin
          if (rx_byte == cfg.start_symbol) begin
            st_next.byte_index    = 16'd1;
            st_next.running_sum   = {8'd0, rx_byte};
            st_next.flags_shift   = 32'd0;
            st_next.received_sum  = 16'd0;
            st_next.header_faults = 2'd0;
            st_next.phase         = PH_HEAD;
          end
        end
        PH_HEAD: begin
          st_next.running_sum = sum_add;
          if (st.byte_index == 16'd1) begin
            st_next.held_module = rx_byte;
          end else if (st.byte_index == 16'd2) begin
            st_next.held_command = rx_byte;
          end else if (st.byte_index == 16'd3) begin
            st_next.held_length = {rx_byte, st.held_length[7:0]};
          end else begin
            st_next.held_length = {st.held_length[15:8], rx_byte};
          end
          st_next.byte_index = idx_inc;
          if (idx_inc >= 16'(HDR_LEN)) begin
            st_next.header_faults = {st_next.held_length > cfg.max_payload_len,
                                     st_next.held_module > cfg.max_module_id};
            st_next.phase = (st_next.held_length == 16'd0) ? PH_FOOT : PH_PAY;
          end
        end
        PH_PAY: begin
          st_next.running_sum = sum_add;
          st_next.byte_index  = idx_inc;
          if ({1'b0, idx_inc} >= frame_end) begin
            st_next.phase = PH_FOOT;
          end
        end
        default: begin
          if (in_flags) begin
            st_next.running_sum = sum_add;
            st_next.flags_shift = {st.flags_shift[23:0], rx_byte};
            st_next.byte_index  = idx_inc;
          end else if (in_sum) begin
            st_next.received_sum = {st.received_sum[7:0], rx_byte};
            st_next.byte_index   = idx_inc;
          end else begin
            st_next.phase      = PH_HUNT;
            st_next.byte_index = 16'd0;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res                = '0;
    res.kind           = KIND_STATUS;
    res.module_id      = st_next.held_module;
    res.command        = st_next.held_command;
    res.payload_length = st_next.held_length;
    res.frame_flags    = st_next.flags_shift;
    if (!func) begin
      if (overflow) begin
        res.overflow_error = 1'b1;
      end else begin
        case (st.phase)
          PH_HUNT: res.start_error = rx_byte != cfg.start_symbol;
          PH_HEAD: ;
          PH_PAY: begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = rx_byte;
          end
          default: begin
            if (!in_sum) begin
              res.kind         = KIND_VERDICT;
              res.module_error = st.header_faults[0];
              res.length_error = st.header_faults[1];
              if (st.header_faults == 2'd0) begin
                res.checksum_error = expect_sum != st.received_sum;
                res.end_error      = rx_byte != cfg.end_symbol;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/framed_packet_receiver.sv =====
// Top level of the framed packet receiver: config registers, state and result register.
// Depends on fpr_pkg and fpr_step.
`timescale 1ns / 1ps

// Byte-stream frame receiver.
// Input channel (in_valid/in_ready) carries func and rx_byte; func high flushes
// the receiver back to hunting for the start symbol. Every input transaction
// produces exactly one result transaction on out_valid/out_ready: a status
// word, a payload byte or, on the end byte, the frame verdict with its errors.
// The result is in the output register the cycle after acceptance.
// Throughput is one byte per cycle while in_ready is high; the whole byte
// update (state step and its 16-bit adds) sits between the state registers
// and the result register. in_ready stays high while the result register is
// empty or is being emptied in the same cycle, so a stalled receiver holds
// back at most one result and the input stalls only while out_ready is low.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; indexes beyond the register list are ignored. Write it only while
// the block is idle.
// Reset clears the receiver to hunting, empties the result register and
// returns the config registers to their defaults (capacity zero, so every
// byte is rejected until capacity is written).

module framed_packet_receiver import fpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [7:0]            payload_byte,
  output logic [7:0]            module_id,
  output logic [7:0]            command,
  output logic [15:0]           payload_length,
  output logic [31:0]           frame_flags,
  output logic                  start_error,
  output logic                  overflow_error,
  output logic                  module_error,
  output logic                  length_error,
  output logic                  checksum_error,
  output logic                  end_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  rx_state_t st;
  rx_state_t st_next;
  result_t   res;
  result_t   res_q;
  logic      in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_symbol    <= 8'd0;
      cfg.end_symbol      <= 8'd0;
      cfg.max_module_id   <= 8'hFF;
      cfg.max_payload_len <= 16'hFFFF;
      cfg.capacity_bytes  <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_SYMBOL:    cfg.start_symbol    <= cfg_data[7:0];
        CFG_END_SYMBOL:      cfg.end_symbol      <= cfg_data[7:0];
        CFG_MAX_MODULE_ID:   cfg.max_module_id   <= cfg_data[7:0];
        CFG_MAX_PAYLOAD_LEN: cfg.max_payload_len <= cfg_data;
        CFG_CAPACITY_BYTES:  cfg.capacity_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  fpr_step u_step (
    .st      (st),
    .cfg     (cfg),
    .func    (func),
    .rx_byte (rx_byte),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_RESET;
      out_valid <= 1'b0;
    end else if (in_accept) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign kind           = res_q.kind;
  assign payload_byte   = res_q.payload_byte;
  assign module_id      = res_q.module_id;
  assign command        = res_q.command;
  assign payload_length = res_q.payload_length;
  assign frame_flags    = res_q.frame_flags;
  assign start_error    = res_q.start_error;
  assign overflow_error = res_q.overflow_error;
  assign module_error   = res_q.module_error;
  assign length_error   = res_q.length_error;
  assign checksum_error = res_q.checksum_error;
  assign end_error      = res_q.end_error;

endmodule

// ===== sv/fpr_checker.sv =====
// Port-level checks for the framed packet receiver, bound to the top level.
// Depends on fpr_pkg and framed_packet_receiver.
`timescale 1ns / 1ps

module fpr_checker import fpr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] payload_byte,
  input logic       start_error,
  input logic       overflow_error,
  input logic       checksum_error,
  input logic       end_error
);

  // each accepted transaction shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted input");

  // input is held off only while a result waits
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result register");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
    else $error("payload byte on a non-payload result");

  a_verdict_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (checksum_error || end_error) |->
      kind == KIND_VERDICT && !start_error && !overflow_error)
    else $error("frame errors outside a verdict");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("result dropped while stalled");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .kind           (kind),
  .payload_byte   (payload_byte),
  .start_error    (start_error),
  .overflow_error (overflow_error),
  .checksum_error (checksum_error),
  .end_error      (end_error)
);

// ===== verif/framed_packet_receiver_tb.sv =====
// Self-checking testbench for framed_packet_receiver: directed table, then random frames.
// Depends on fpr_pkg and the receiver RTL; expected results come from an in-bench predictor.
`timescale 1ns / 1ps

module framed_packet_receiver_tb;
  import fpr_pkg::*;

  localparam int N_PHASES       = 13;
  localparam int HOLD_PHASE     = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // indexes past the register list, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_LAST  = 3'd7;

  // error flag set {start, overflow, module, length, checksum, end}
  localparam logic [5:0] NO_ERR  = 6'b000000;
  localparam logic [5:0] E_START = 6'b100000;
  localparam logic [5:0] E_OVER  = 6'b010000;
  localparam logic [5:0] E_MOD   = 6'b001000;
  localparam logic [5:0] E_LEN   = 6'b000100;

  typedef enum logic [1:0] {ROW_BYTE, ROW_FLUSH, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           data;   // byte in [7:0] for data rows
    logic                  fixed;  // kind and flags typed in below
    kind_t                 kind;
    logic [5:0]            errs;
  } dir_row_t;

  typedef struct packed {
    logic  fixed;
    kind_t kind;
    logic [5:0] errs;
  } typed_exp_t;

  localparam int N_DIRECTED = 36;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // capacity is zero out of reset, so the first byte is dropped
    '{ROW_BYTE,  '0, 16'h00FF, 1'b1, KIND_STATUS,  E_OVER},
    '{ROW_FLUSH, '0, 16'h0000, 1'b1, KIND_STATUS,  NO_ERR},
    '{ROW_CFG,   CFG_CAPACITY_BYTES,  16'hFFFF, 1'b0, KIND_STATUS, NO_ERR},
    '{ROW_CFG,   CFG_START_SYMBOL,    16'h00A5, 1'b0, KIND_STATUS, NO_ERR},
    '{ROW_CFG,   CFG_END_SYMBOL,      16'h005A, 1'b0, KIND_STATUS, NO_ERR},
    '{ROW_CFG,   CFG_NONE_FIRST,      16'h1234, 1'b0, KIND_STATUS, NO_ERR},
    '{ROW_CFG,   CFG_MAX_MODULE_ID,   16'h00FF, 1'b0, KIND_STATUS, NO_ERR},
    '{ROW_CFG,   CFG_MAX_PAYLOAD_LEN, 16'hFFFF, 1'b0, KIND_STATUS, NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b1, KIND_STATUS,  E_START},
    // clean zero-length frame, module id at the limit
    '{ROW_BYTE,  '0, 16'h00A5, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h00FF, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h00FF, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h00FF, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h00FF, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h00FF, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h00FA, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0060, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h005A, 1'b1, KIND_VERDICT, NO_ERR},
    '{ROW_CFG,   CFG_MAX_MODULE_ID,   16'h0010, 1'b0, KIND_STATUS, NO_ERR},
    '{ROW_CFG,   CFG_MAX_PAYLOAD_LEN, 16'h0000, 1'b0, KIND_STATUS, NO_ERR},
    // both header limits broken: checksum and end byte are not judged
    '{ROW_BYTE,  '0, 16'h00A5, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0020, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h00C3, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0001, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0080, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0001, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0002, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0004, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0008, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b0, KIND_STATUS,  NO_ERR},
    '{ROW_BYTE,  '0, 16'h0000, 1'b1, KIND_VERDICT, E_MOD | E_LEN}
  };

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  func;
  logic [7:0]            rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            kind;
  logic [7:0]            payload_byte;
  logic [7:0]            module_id;
  logic [7:0]            command;
  logic [15:0]           payload_length;
  logic [31:0]           frame_flags;
  logic                  start_error;
  logic                  overflow_error;
  logic                  module_error;
  logic                  length_error;
  logic                  checksum_error;
  logic                  end_error;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rx_state_t  rx_model;
  cfg_t       cfg_model;
  result_t    rx_expected [$];
  typed_exp_t row_checks [$];

  int  error_count     = 0;
  int  results_checked = 0;
  int  verdicts_seen   = 0;
  int  items_sent      = 0;
  int  cfg_writes      = 0;
  int  quiet_cycles    = 0;
  int  calm_tx         = 0;
  int  calm_rx         = 0;
  bit  hold_req        = 1'b0;

  framed_packet_receiver u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .module_id      (module_id),
    .command        (command),
    .payload_length (payload_length),
    .frame_flags    (frame_flags),
    .start_error    (start_error),
    .overflow_error (overflow_error),
    .module_error   (module_error),
    .length_error   (length_error),
    .checksum_error (checksum_error),
    .end_error      (end_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones, and calm stretches.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      calm = $urandom_range(50, 150);
      return 0;
    end
    if (r < 130) return 0;
    if (r < 185) return $urandom_range(1, 3);
    if (r < 197) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Advances the receiver model by one byte (or flush) and returns its output.
  function automatic result_t predict_rx_byte(input logic flush, input logic [7:0] b);
    result_t     r;
    int unsigned pos;
    logic [15:0] want_sum;
    r = '0;
    r.kind = KIND_STATUS;
    if (flush) begin
      rx_model.phase = PH_HUNT;
      rx_model.byte_index = '0;
    end else if (rx_model.byte_index >= cfg_model.capacity_bytes) begin
      r.overflow_error = 1'b1;
    end else begin
      case (rx_model.phase)
        PH_HUNT: begin
          if (b != cfg_model.start_symbol) begin
            r.start_error = 1'b1;
          end else begin
            rx_model.byte_index    = 16'd1;
            rx_model.running_sum   = {8'h00, b};
            rx_model.flags_shift   = '0;
            rx_model.received_sum  = '0;
            rx_model.header_faults = '0;
            rx_model.phase         = PH_HEAD;
          end
        end
        PH_HEAD: begin
          rx_model.running_sum = rx_model.running_sum + b;
          case (rx_model.byte_index)
            16'd1:   rx_model.held_module = b;
            16'd2:   rx_model.held_command = b;
            16'd3:   rx_model.held_length[15:8] = b;
            default: rx_model.held_length[7:0] = b;
          endcase
          rx_model.byte_index = rx_model.byte_index + 16'd1;
          if (rx_model.byte_index >= HDR_LEN) begin
            rx_model.header_faults[0] = rx_model.held_module > cfg_model.max_module_id;
            rx_model.header_faults[1] = rx_model.held_length > cfg_model.max_payload_len;
            rx_model.phase = (rx_model.held_length == 16'd0) ? PH_FOOT : PH_PAY;
          end
        end
        PH_PAY: begin
          rx_model.running_sum = rx_model.running_sum + b;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          rx_model.byte_index = rx_model.byte_index + 16'd1;
          if (rx_model.byte_index >= HDR_LEN + rx_model.held_length)
            rx_model.phase = PH_FOOT;
        end
        default: begin
          pos = rx_model.byte_index - (HDR_LEN + rx_model.held_length);
          if (pos < FLAGS_BYTES) begin
            rx_model.running_sum = rx_model.running_sum + b;
            rx_model.flags_shift = {rx_model.flags_shift[23:0], b};
            rx_model.byte_index  = rx_model.byte_index + 16'd1;
          end else if (pos < SUM_END) begin
            rx_model.received_sum = {rx_model.received_sum[7:0], b};
            rx_model.byte_index   = rx_model.byte_index + 16'd1;
          end else begin
            want_sum = ~rx_model.running_sum + 16'd1;
            r.kind = KIND_VERDICT;
            r.module_error = rx_model.header_faults[0];
            r.length_error = rx_model.header_faults[1];
            if (rx_model.header_faults == 2'b00) begin
              r.checksum_error = want_sum != rx_model.received_sum;
              r.end_error      = b != cfg_model.end_symbol;
            end
            rx_model.phase      = PH_HUNT;
            rx_model.byte_index = '0;
          end
        end
      endcase
    end
    r.module_id      = rx_model.held_module;
    r.command        = rx_model.held_command;
    r.payload_length = rx_model.held_length;
    r.frame_flags    = rx_model.flags_shift;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // Scoreboard: results, register writes and input transactions at each edge.
  always @(posedge clk) begin : rx_monitor
    result_t    want;
    typed_exp_t note;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (rx_expected.size() == 0) begin
          $error("result transaction with nothing expected (kind %0d)", kind);
          error_count++;
        end else begin
          want = rx_expected.pop_front();
          check_field("kind", want.kind, kind);
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("module_id", want.module_id, module_id);
          check_field("command", want.command, command);
          check_field("payload_length", want.payload_length, payload_length);
          check_field("frame_flags", want.frame_flags, frame_flags);
          check_field("start_error", want.start_error, start_error);
          check_field("overflow_error", want.overflow_error, overflow_error);
          check_field("module_error", want.module_error, module_error);
          check_field("length_error", want.length_error, length_error);
          check_field("checksum_error", want.checksum_error, checksum_error);
          check_field("end_error", want.end_error, end_error);
          results_checked++;
          if (want.kind == KIND_VERDICT) verdicts_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_SYMBOL:    cfg_model.start_symbol    = cfg_data[7:0];
          CFG_END_SYMBOL:      cfg_model.end_symbol      = cfg_data[7:0];
          CFG_MAX_MODULE_ID:   cfg_model.max_module_id   = cfg_data[7:0];
          CFG_MAX_PAYLOAD_LEN: cfg_model.max_payload_len = cfg_data;
          CFG_CAPACITY_BYTES:  cfg_model.capacity_bytes  = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        want = predict_rx_byte(func, rx_byte);
        if (row_checks.size() != 0) begin
          note = row_checks.pop_front();
          if (note.fixed) begin
            want.kind = note.kind;
            {want.start_error, want.overflow_error, want.module_error,
             want.length_error, want.checksum_error, want.end_error} = note.errs;
          end
        end
        rx_expected.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, rx_expected.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : rx_sink
    int g;
    out_ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        g = pick_gap(calm_rx);
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (g - 1) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(input logic flush, input logic [7:0] b);
    int g;
    g = pick_gap(calm_tx);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= flush;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (rx_expected.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // One well-formed frame with random content, sometimes broken, or a burst of noise.
  task automatic send_frame();
    logic [8:0]  seq [$];
    logic [7:0]  body [$];
    logic [15:0] sum;
    logic [15:0] len;
    logic [15:0] chk;
    logic [7:0]  fin;
    int          cut;
    int          k;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 8)) seq.push_back({($urandom_range(0, 7) == 0), 8'($urandom)});
    end else begin
      if ($urandom_range(0, 4) == 0) seq.push_back({1'b1, 8'($urandom)});
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 24)) : 16'($urandom_range(0, 6));
      body.push_back(cfg_model.start_symbol);
      body.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, cfg_model.max_module_id))
                                          : 8'($urandom));
      body.push_back(8'($urandom));
      body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      repeat (len + FLAGS_BYTES) body.push_back(8'($urandom));
      sum = '0;
      foreach (body[i]) begin
        sum = sum + body[i];
        seq.push_back({1'b0, body[i]});
      end
      chk = ~sum + 16'd1;
      if ($urandom_range(0, 4) == 0) chk = chk ^ (16'd1 << $urandom_range(0, 15));
      fin = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cfg_model.end_symbol;
      seq.push_back({1'b0, chk[15:8]});
      seq.push_back({1'b0, chk[7:0]});
      seq.push_back({1'b0, fin});
      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(0, seq.size() - 1);
        seq[k][7:0] = seq[k][7:0] ^ (8'd1 << $urandom_range(0, 7));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, seq.size() - 1);
        seq = seq[0:cut-1];
        seq.push_back({1'b1, 8'($urandom)});
      end
    end
    foreach (seq[i]) send_item(seq[i][8], seq[i][7:0]);
    items_sent += seq.size();
  endtask

  initial begin : stimulus
    int          target;
    logic [7:0]  s_start;
    logic [7:0]  s_end;
    logic [7:0]  s_mod;
    logic [15:0] s_len;
    logic [15:0] s_cap;
    int          pick;
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = 1'b0;
    rx_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rx_model  = STATE_RESET;
    cfg_model = '{start_symbol: 8'h00, end_symbol: 8'h00, max_module_id: 8'hFF,
                  max_payload_len: 16'hFFFF, capacity_bytes: 16'h0000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].op == ROW_CFG) begin
        drain_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        row_checks.push_back('{DIRECTED[i].fixed, DIRECTED[i].kind, DIRECTED[i].errs});
        send_item(DIRECTED[i].op == ROW_FLUSH, DIRECTED[i].data[7:0]);
        items_sent++;
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      if (p == 0) begin
        {s_start, s_end, s_mod, s_len, s_cap} = '0;
      end else if (p == 1) begin
        {s_start, s_end, s_mod, s_len, s_cap} = '1;
      end else begin
        s_start = 8'($urandom);
        s_end   = 8'($urandom);
        s_mod   = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
        s_len   = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 12));
        pick    = $urandom_range(0, 99);
        if (pick < 55)      s_cap = 16'hFFFF;
        else if (pick < 85) s_cap = 16'($urandom_range(HDR_LEN, 40));
        else if (pick < 92) s_cap = 16'($urandom_range(0, 4));
        else                s_cap = 16'($urandom);
      end
      write_reg(CFG_START_SYMBOL, {8'h00, s_start});
      write_reg(CFG_END_SYMBOL, {8'h00, s_end});
      write_reg(CFG_MAX_MODULE_ID, {8'h00, s_mod});
      write_reg(CFG_MAX_PAYLOAD_LEN, s_len);
      write_reg(CFG_CAPACITY_BYTES, s_cap);
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_NONE_FIRST, CFG_NONE_LAST)), 16'($urandom));
      // the sink stalls for a long stretch while bytes keep coming
      if (p == HOLD_PHASE) hold_req = 1'b1;
      target = items_sent + ((p == 0) ? 40 : 140);
      while (items_sent < target) send_frame();
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Run covered %0d input bytes, %0d results checked, %0d frame verdicts,",
             items_sent, results_checked, verdicts_seen);
    $display("%0d register writes over %0d settings, %0d mismatches.",
             cfg_writes, N_PHASES + 2, error_count);
    if (error_count == 0 && rx_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
